FILE: rtl/core/sfpw_pkg.sv
// Shared types, codes and the step function of the small fast generator.
package sfpw_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CntW = 9;
	localparam logic [WordW-1:0] InitA = 32'hf1ea5eed;

	localparam logic REQ_NEXT = 1'b0;
	localparam logic REQ_SEED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PASS
	} state_t;

	typedef struct packed {
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic [WordW-1:0] c;
		logic [WordW-1:0] d;
	} words_t;

	typedef struct packed {
		logic load;
		logic step;
		logic cnt_inc;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic cnt_lt;
	} status_t;

	function automatic words_t sfpw_step(words_t w);
		words_t r;
		logic [WordW-1:0] e;
		e = w.a - {w.b[4:0], w.b[31:5]};
		r.a = w.b ^ {w.c[14:0], w.c[31:15]};
		r.b = w.c + w.d;
		r.c = w.d + e;
		r.d = e + r.a;
		return r;
	endfunction

endpackage

FILE: rtl/core/small_fast_prng_with_warmup_core.sv
// Top level of the small fast generator with seeded warm-up.
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | req_type, seed_value
//   out     | output    | out_valid/out_stall | random_value
// A next request steps the state; the value waits in an output register.
// A seed request loads the state, then runs warm-up check-and-pass rounds of
// the single step unit until the count is no longer below word d[7:0].
// Reset clears all state words, so unseeded requests return zero.
// in_stall is high during warm-up and while a held result is stalled.
module small_fast_prng_with_warmup_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] random_value
);

	sfpw_pkg::cmd_t cmd;
	sfpw_pkg::status_t sts;

	sfpw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	sfpw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.seed_value   (seed_value),
		.random_value (random_value)
	);

endmodule

FILE: rtl/core/sfpw_ctrl.sv
// Controller: request decode, warm-up sequencing and output valid.
module sfpw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             req_type,
	output logic             out_valid,
	input  logic             out_stall,
	output sfpw_pkg::cmd_t   cmd,
	input  sfpw_pkg::status_t sts
);

	sfpw_pkg::state_t state_q, state_nx;
	logic out_valid_q;
	logic in_xfer;

	assign in_stall = (state_q != sfpw_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign in_xfer = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sfpw_pkg::ST_IDLE: begin
				if (in_xfer && req_type == sfpw_pkg::REQ_SEED) state_nx = sfpw_pkg::ST_CHECK;
			end
			sfpw_pkg::ST_CHECK: state_nx = sfpw_pkg::ST_PASS;
			sfpw_pkg::ST_PASS: begin
				state_nx = sts.cnt_lt ? sfpw_pkg::ST_CHECK : sfpw_pkg::ST_IDLE;
			end
			default: state_nx = sfpw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			sfpw_pkg::ST_IDLE: begin
				cmd.load = in_xfer && req_type == sfpw_pkg::REQ_SEED;
				cmd.step = in_xfer && req_type == sfpw_pkg::REQ_NEXT;
				cmd.capture = in_xfer && req_type == sfpw_pkg::REQ_NEXT;
			end
			sfpw_pkg::ST_CHECK: cmd.step = 1'b1;
			sfpw_pkg::ST_PASS: begin
				cmd.step = sts.cnt_lt;
				cmd.cnt_inc = sts.cnt_lt;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfpw_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.capture) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/sfpw_dp.sv
// Datapath: state words, warm-up counter and result register.
module sfpw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfpw_pkg::cmd_t                cmd,
	output sfpw_pkg::status_t             sts,
	input  logic [sfpw_pkg::WordW-1:0]    seed_value,
	output logic [sfpw_pkg::WordW-1:0]    random_value
);

	sfpw_pkg::words_t words_q, words_nx;
	logic [sfpw_pkg::CntW-1:0] cnt_q;
	logic [sfpw_pkg::WordW-1:0] result_q;

	assign words_nx = sfpw_pkg::sfpw_step(words_q);
	assign sts.cnt_lt = cnt_q < {1'b0, words_q.d[7:0]};
	assign random_value = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				words_q.a <= sfpw_pkg::InitA;
				words_q.b <= seed_value;
				words_q.c <= seed_value;
				words_q.d <= seed_value;
				cnt_q <= '0;
			end else begin
				if (cmd.step) words_q <= words_nx;
				if (cmd.cnt_inc) cnt_q <= cnt_q + sfpw_pkg::CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) result_q <= words_nx.d;
	end

endmodule

FILE: rtl/core/sfpw_checker.sv
// Port-level checker for the generator core, bound to the top level.
module sfpw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        req_type,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] random_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(random_value))
		else $error("stalled result changed");

	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type == sfpw_pkg::REQ_SEED |=> in_stall)
		else $error("input not stalled during warm-up");

	a_next_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type == sfpw_pkg::REQ_NEXT |=> out_valid)
		else $error("next transfer gave no result");

endmodule

bind small_fast_prng_with_warmup_core sfpw_checker u_sfpw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.req_type     (req_type),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.random_value (random_value)
);

FILE: dv/small_fast_prng_with_warmup_core_test.sv
// Testbench for the small fast generator core: predicted outputs under random flow control.
module small_fast_prng_with_warmup_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 4_000_000;
	localparam int DrainCycles = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = sfpw_pkg::REQ_NEXT;
	logic [31:0] seed_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] random_value;

	bit [31:0] gen_a, gen_b, gen_c, gen_d;
	bit [8:0]  warm_cnt;
	bit [31:0] values_due[$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        hold_off_left = 0;
	int        stall_run = 0;
	int        stall_mode = 0;

	small_fast_prng_with_warmup_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value)
	);

	always #4 clk = ~clk;

	function automatic bit [31:0] rotl32(bit [31:0] x, int unsigned k);
		return (x << k) | (x >> (32 - k));
	endfunction

	function automatic bit [31:0] gen_advance();
		bit [31:0] e;
		e = gen_a - rotl32(gen_b, 27);
		gen_a = gen_b ^ rotl32(gen_c, 17);
		gen_b = gen_c + gen_d;
		gen_c = gen_d + e;
		gen_d = e + gen_a;
		return gen_d;
	endfunction

	function automatic void gen_reseed(bit [31:0] seed);
		bit [31:0] limit;
		bit        warming;
		gen_a = sfpw_pkg::InitA;
		gen_b = seed;
		gen_c = seed;
		gen_d = seed;
		warm_cnt = '0;
		warming = 1'b1;
		while (warming) begin
			limit = gen_advance() & 32'hFF;
			if (warm_cnt < limit) begin
				void'(gen_advance());
				warm_cnt = warm_cnt + 9'd1;
			end else begin
				warming = 1'b0;
			end
		end
	endfunction

	// input transfers feed the predictor, output transfers are checked
	always @(posedge clk) begin : monitor
		bit [31:0] want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (req_type == sfpw_pkg::REQ_NEXT)
					values_due.push_back(gen_advance());
				else
					gen_reseed(seed_value);
			end
			if (out_valid && !out_stall) begin
				if (values_due.size() == 0) begin
					$display("%0t: unexpected random_value expected none actual %h",
						$time, random_value);
					mismatches++;
				end else begin
					want = values_due.pop_front();
					if (random_value !== want) begin
						$display("%0t: random_value expected %h actual %h",
							$time, want, random_value);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: timeout", $time);
			$display("small_fast_prng_with_warmup_core_test NOT OK");
			$finish;
		end
	end

	// receiver: quiet stretches, light stalling, long bursts, forced hold-off
	always @(negedge clk) begin
		if (hold_off_left != 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else begin
			if (stall_run == 0) begin
				case ($urandom_range(0, 9))
					0: begin
						stall_mode = 2;
						stall_run = $urandom_range(10, 50);
					end
					1, 2, 3, 4: begin
						stall_mode = 0;
						stall_run = $urandom_range(10, 80);
					end
					default: begin
						stall_mode = 1;
						stall_run = $urandom_range(10, 80);
					end
				endcase
			end
			stall_run--;
			case (stall_mode)
				2: out_stall <= 1'b1;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	task automatic send_req(input logic kind, input logic [31:0] seed, input int gap);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			req_type <= $urandom_range(0, 1);
			seed_value <= $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		seed_value <= seed;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (values_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_unseeded_and_extremes();
		send_req(sfpw_pkg::REQ_NEXT, 32'h0000_0000, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'hFFFF_FFFF, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'h1234_5678, 1);
		send_req(sfpw_pkg::REQ_SEED, 32'h0000_0000, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'hFFFF_FFFF, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'h0000_0000, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'hA5A5_A5A5, 2);
		send_req(sfpw_pkg::REQ_SEED, 32'hFFFF_FFFF, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'h0000_0000, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'hFFFF_FFFF, 0);
		send_req(sfpw_pkg::REQ_SEED, 32'h0000_0001, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'h0000_0000, 0);
		send_req(sfpw_pkg::REQ_SEED, 32'h8000_0000, 3);
		send_req(sfpw_pkg::REQ_NEXT, 32'h5555_5555, 0);
		send_req(sfpw_pkg::REQ_SEED, $urandom, 0);
		send_req(sfpw_pkg::REQ_SEED, $urandom, 0);
		send_req(sfpw_pkg::REQ_NEXT, $urandom, 0);
		send_req(sfpw_pkg::REQ_NEXT, $urandom, 0);
		send_req(sfpw_pkg::REQ_SEED, 32'h7FFF_FFFF, 0);
		send_req(sfpw_pkg::REQ_NEXT, 32'hAAAA_AAAA, 0);
		go_idle();
	endtask

	task automatic test_random_traffic();
		logic [31:0] seed;
		logic        kind;
		int          gap;
		for (int i = 0; i < 1600; i++) begin
			kind = ($urandom_range(0, 24) == 0) ? sfpw_pkg::REQ_SEED : sfpw_pkg::REQ_NEXT;
			case ($urandom_range(0, 15))
				0: seed = 32'h0000_0000;
				1: seed = 32'hFFFF_FFFF;
				default: seed = $urandom;
			endcase
			gap = ((i / 50) % 3 == 0) ? 0 : pick_gap();
			send_req(kind, seed, gap);
		end
		go_idle();
	endtask

	task automatic test_output_hold_off();
		hold_off_left = 250;
		for (int i = 0; i < 16; i++)
			send_req((i == 5) ? sfpw_pkg::REQ_SEED : sfpw_pkg::REQ_NEXT, $urandom, 0);
		go_idle();
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 8; i++)
			send_req(sfpw_pkg::REQ_NEXT, $urandom, pick_gap());
		go_idle();
		wait_drained();
		send_req(sfpw_pkg::REQ_SEED, $urandom, 0);
		for (int i = 0; i < 6; i++)
			send_req(sfpw_pkg::REQ_NEXT, $urandom, 0);
		go_idle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_unseeded_and_extremes();
		test_output_hold_off();
		test_random_traffic();
		test_drain_pause();
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && values_due.size() == 0)
			$display("small_fast_prng_with_warmup_core_test OK");
		else
			$display("small_fast_prng_with_warmup_core_test NOT OK");
		$finish;
	end

endmodule
